// ===== rtl/pfc_pkg.sv =====
package pfc_pkg;

   localparam int unsigned PAGES_DEFAULT      = 23;
   localparam int unsigned SPEED_STEP_DEFAULT = 100;
   localparam int unsigned DEFAULT_FAN_PAGES  = 6;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned CMD_W   = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned LEN_W   = 6;
   localparam int unsigned BYTE_W  = 8;

   // transaction kinds
   localparam logic [OP_W-1:0] OP_SEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PAGE          = 8'h00;
   localparam logic [CMD_W-1:0] CMD_CLEAR_FAULTS  = 8'h03;
   localparam logic [CMD_W-1:0] CMD_CAPABILITY    = 8'h19;
   localparam logic [CMD_W-1:0] CMD_VOUT_MODE     = 8'h20;
   localparam logic [CMD_W-1:0] CMD_FAN_CONFIG_12 = 8'h3a;
   localparam logic [CMD_W-1:0] CMD_FAN_COMMAND_1 = 8'h3b;
   localparam logic [CMD_W-1:0] CMD_FAN_COMMAND_2 = 8'h3c;
   localparam logic [CMD_W-1:0] CMD_FAN_CONFIG_34 = 8'h3d;
   localparam logic [CMD_W-1:0] CMD_FAN_COMMAND_3 = 8'h3e;
   localparam logic [CMD_W-1:0] CMD_FAN_COMMAND_4 = 8'h3f;
   localparam logic [CMD_W-1:0] CMD_STATUS_BYTE   = 8'h78;
   localparam logic [CMD_W-1:0] CMD_STATUS_FANS_12 = 8'h81;
   localparam logic [CMD_W-1:0] CMD_STATUS_FANS_34 = 8'h82;
   localparam logic [CMD_W-1:0] CMD_FAN_SPEED_1   = 8'h90;

   localparam logic [BYTE_W-1:0] CAPABILITY_VALUE    = 8'h00;
   localparam logic [BYTE_W-1:0] VOUT_MODE_VALUE     = 8'h40;
   localparam logic [BYTE_W-1:0] SUMMARY_CML_BIT     = 8'h02;
   localparam logic [BYTE_W-1:0] CML_INVALID_CMD_BIT = 8'h80;
   localparam logic [BYTE_W-1:0] FAN_A_INSTALLED     = 8'h80;

   localparam logic [LEN_W-1:0] FAN_CMD_LEN = 6'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // everything one page keeps, one memory word
   typedef struct packed {
      logic [BYTE_W-1:0]             fan_config_low_pair;
      logic [BYTE_W-1:0]             fan_config_high_pair;
      logic [3:0][VALUE_W-1:0]       fan_command_words;
      logic [BYTE_W-1:0]             summary_status;
      logic [BYTE_W-1:0]             comm_fault_status;
      logic [BYTE_W-1:0]             fan_status_low_pair;
      logic [BYTE_W-1:0]             fan_status_high_pair;
      logic [VALUE_W-1:0]            fan_speed_one;
   } page_rec_type;

   function automatic logic [1:0] fan_slot(input logic [CMD_W-1:0] cmd);
      logic [1:0] slot;
      case (cmd)
         CMD_FAN_COMMAND_1: slot = 2'd0;
         CMD_FAN_COMMAND_2: slot = 2'd1;
         CMD_FAN_COMMAND_3: slot = 2'd2;
         CMD_FAN_COMMAND_4: slot = 2'd3;
         default:           slot = 2'd0;
      endcase
      return slot;
   endfunction

endpackage

// ===== rtl/pfc_channels.sv =====
interface pfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::OP_W-1:0]     op;
   logic [pfc_pkg::CMD_W-1:0]    cmd;
   logic [pfc_pkg::VALUE_W-1:0]  write_value;
   logic [pfc_pkg::LEN_W-1:0]    write_len;
   logic                         byte_index;

   modport source (output valid, op, cmd, write_value, write_len, byte_index, input ready);
   modport sink   (input valid, op, cmd, write_value, write_len, byte_index, output ready);
endinterface

interface pfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::BYTE_W-1:0]   read_byte;

   modport source (output valid, read_byte, input ready);
   modport sink   (input valid, read_byte, output ready);
endinterface

// ===== rtl/pmbus_fan_controller_regs_top.sv =====
// Paged PMBus command register file for a fan controller. Each request is one
// SMBus transaction (send byte, write, or read of one byte) on the page chosen by
// PAGE; every request gives exactly one response byte, zero for non-reads. A
// transaction first reads the page's record from the page memory, whose read
// is registered, then modifies it, writes it back and loads the response
// register. A new request is taken while a response still waits, but its
// write-back holds until the response register is free. Pages that
// were never written read as their reset contents through a valid bit per page,
// so the block is ready straight after reset with no clearing pass.
module pmbus_fan_controller_regs_top #(
   parameter int unsigned PAGES      = pfc_pkg::PAGES_DEFAULT,
   parameter int unsigned SPEED_STEP = pfc_pkg::SPEED_STEP_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   pfc_req_if.sink   req_ch,
   pfc_rsp_if.source rsp_ch
);
   import pfc_pkg::*;

   localparam int unsigned PageW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic [BYTE_W-1:0]  PageLimit = BYTE_W'(PAGES);
   localparam logic [VALUE_W-1:0] SpeedStep = VALUE_W'(SPEED_STEP);

   state_type state_ff, state_in;

   logic [PageW-1:0]   page_ff, page_in;
   logic [PAGES-1:0]   valid_ff;
   page_rec_type       mem [PAGES];
   page_rec_type       rd_ff;

   logic [OP_W-1:0]    op_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               idx_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  read_byte_ff, read_byte_in;

   logic               req_take;
   logic               exec_done;
   page_rec_type       cur_rec, new_rec;
   logic [VALUE_W-1:0] speed_next;
   logic [1:0]         slot;

   // state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_EXEC;
         ST_EXEC: if (exec_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      exec_done    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_EXEC: exec_done = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_take        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_byte = read_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         page_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_done) begin
            page_ff           <= page_in;
            valid_ff[page_ff] <= 1'b1;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // page memory, registered read at acceptance, write-back at the end
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_ff <= mem[page_ff];
      end
      if (exec_done) begin
         mem[page_ff] <= new_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_ch.op;
         cmd_ff   <= req_ch.cmd;
         value_ff <= req_ch.write_value;
         len_ff   <= req_ch.write_len;
         idx_ff   <= req_ch.byte_index;
      end
      if (exec_done) begin
         read_byte_ff <= read_byte_in;
      end
   end

   // untouched pages read as their reset contents
   always_comb begin
      if (valid_ff[page_ff]) begin
         cur_rec = rd_ff;
      end else begin
         cur_rec = '0;
         if (int'(page_ff) < DEFAULT_FAN_PAGES) begin
            cur_rec.fan_config_low_pair = FAN_A_INSTALLED;
         end
      end
   end

   assign slot       = fan_slot(cmd_ff);
   assign speed_next = cur_rec.fan_speed_one + SpeedStep;

   always_comb begin
      new_rec      = cur_rec;
      page_in      = page_ff;
      read_byte_in = '0;
      case (op_ff)
         OP_SEND: begin
            if (cmd_ff == CMD_CLEAR_FAULTS) begin
               new_rec.summary_status    = '0;
               new_rec.comm_fault_status = '0;
            end else begin
               new_rec.summary_status    = cur_rec.summary_status | SUMMARY_CML_BIT;
               new_rec.comm_fault_status = cur_rec.comm_fault_status | CML_INVALID_CMD_BIT;
            end
         end
         OP_WRITE: begin
            case (cmd_ff)
               CMD_FAN_COMMAND_1, CMD_FAN_COMMAND_2, CMD_FAN_COMMAND_3,
               CMD_FAN_COMMAND_4: begin
                  if (len_ff == FAN_CMD_LEN) new_rec.fan_command_words[slot] = value_ff;
               end
               CMD_PAGE: begin
                  if (value_ff[BYTE_W-1:0] < PageLimit) page_in = value_ff[PageW-1:0];
               end
               CMD_FAN_CONFIG_12:  new_rec.fan_config_low_pair  = value_ff[BYTE_W-1:0];
               CMD_FAN_CONFIG_34:  new_rec.fan_config_high_pair = value_ff[BYTE_W-1:0];
               CMD_STATUS_FANS_12: new_rec.fan_status_low_pair  = value_ff[BYTE_W-1:0];
               CMD_STATUS_FANS_34: new_rec.fan_status_high_pair = value_ff[BYTE_W-1:0];
               default: begin
                  new_rec.summary_status    = cur_rec.summary_status | SUMMARY_CML_BIT;
                  new_rec.comm_fault_status = cur_rec.comm_fault_status | CML_INVALID_CMD_BIT;
               end
            endcase
         end
         OP_READ: begin
            case (cmd_ff)
               CMD_FAN_COMMAND_1, CMD_FAN_COMMAND_2, CMD_FAN_COMMAND_3,
               CMD_FAN_COMMAND_4: begin
                  read_byte_in = idx_ff ? cur_rec.fan_command_words[slot][15:8]
                                        : cur_rec.fan_command_words[slot][7:0];
               end
               CMD_PAGE:           read_byte_in = BYTE_W'(page_ff);
               CMD_CAPABILITY:     read_byte_in = CAPABILITY_VALUE;
               CMD_VOUT_MODE:      read_byte_in = VOUT_MODE_VALUE;
               CMD_FAN_CONFIG_12:  read_byte_in = cur_rec.fan_config_low_pair;
               CMD_FAN_CONFIG_34:  read_byte_in = cur_rec.fan_config_high_pair;
               CMD_STATUS_BYTE:    read_byte_in = cur_rec.summary_status;
               CMD_STATUS_FANS_12: read_byte_in = cur_rec.fan_status_low_pair;
               CMD_STATUS_FANS_34: read_byte_in = cur_rec.fan_status_high_pair;
               CMD_FAN_SPEED_1: begin
                  // low byte read advances the simulated tach count
                  if (!idx_ff) begin
                     new_rec.fan_speed_one = speed_next;
                     read_byte_in          = speed_next[7:0];
                  end else begin
                     read_byte_in = cur_rec.fan_speed_one[15:8];
                  end
               end
               default: begin
                  new_rec.summary_status    = cur_rec.summary_status | SUMMARY_CML_BIT;
                  new_rec.comm_fault_status = cur_rec.comm_fault_status | CML_INVALID_CMD_BIT;
               end
            endcase
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/pfc_checker.sv =====
module pfc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [pfc_pkg::OP_W-1:0]     req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pfc_pkg::BYTE_W-1:0]   rsp_read_byte
);
   import pfc_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // one transaction at a time
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_xfer)
      else $error("request transfer in the cycle after a transfer");

   // with the response slot empty, the execute state loads the response register without a stall
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !rsp_valid) |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   // send and write transactions return zero
   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !rsp_valid && req_op != OP_READ) |=> ##1 (rsp_read_byte == '0))
      else $error("non-read transaction returned a nonzero byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_read_byte))
      else $error("response byte changed while stalled");

endmodule

bind pmbus_fan_controller_regs_top pfc_checker u_pfc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_op        (req_ch.op),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_byte (rsp_ch.read_byte)
);
